[rtl/u2a_pkg.sv]
package u2a_pkg;

  // Width the block is built for, and the width that is really converted.
  // The value port is 32 bits wide, so no more than 32 bits can ever matter.
  localparam int VALUE_WIDTH = 32;
  localparam int PORT_W      = 32;
  localparam int DATA_W      = (VALUE_WIDTH < PORT_W) ? VALUE_WIDTH : PORT_W;

  // Digit count: at most DATA_W digits (base two).
  localparam int CNT_W   = $clog2(DATA_W + 1);
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

  // 2^DATA_W, used to build the reciprocal table.
  localparam longint unsigned POW_W = 64'd1 << DATA_W;

  // One conversion job as it leaves the front part.
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [RADIX_W-1:0] radix;
    logic               err;
  } job_t;

  // Reciprocal floor(2^DATA_W / radix). The quotient estimate taken from it
  // is never above the true quotient and at most one below.
  function automatic logic [DATA_W-1:0] u2a_recip(input logic [RADIX_W-1:0] radix);
    logic [DATA_W-1:0] r;
    unique case (radix)
      5'd2:    r = DATA_W'(POW_W / 2);
      5'd3:    r = DATA_W'(POW_W / 3);
      5'd4:    r = DATA_W'(POW_W / 4);
      5'd5:    r = DATA_W'(POW_W / 5);
      5'd6:    r = DATA_W'(POW_W / 6);
      5'd7:    r = DATA_W'(POW_W / 7);
      5'd8:    r = DATA_W'(POW_W / 8);
      5'd9:    r = DATA_W'(POW_W / 9);
      5'd10:   r = DATA_W'(POW_W / 10);
      5'd11:   r = DATA_W'(POW_W / 11);
      5'd12:   r = DATA_W'(POW_W / 12);
      5'd13:   r = DATA_W'(POW_W / 13);
      5'd14:   r = DATA_W'(POW_W / 14);
      5'd15:   r = DATA_W'(POW_W / 15);
      5'd16:   r = DATA_W'(POW_W / 16);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Lower-case ASCII character of one digit.
  function automatic logic [CHAR_W-1:0] u2a_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (dx < DIGIT_TEN) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_LOWA + dx - DIGIT_TEN;
  endfunction

endpackage

[rtl/u2a_front.sv]
module u2a_front import u2a_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PORT_W-1:0]   in_value,
  input  logic [RADIX_W-1:0]  in_radix,
  output logic                job_valid,
  input  logic                job_ready,
  output job_t                job
);

  // Two-entry queue of classified jobs.
  job_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  job_t       in_job;

  // Classify the incoming item: out-of-range bases become error jobs.
  always_comb begin
    in_job.value = in_value[DATA_W-1:0];
    in_job.radix = in_radix;
    in_job.err   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  end

  assign in_ready  = (count_r != 2'd2);
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_job;
    end
  end

  // The fill count never passes the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue fill count out of range");

  // With both entries in use the pointers meet.
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue full but pointers differ");

  // A valid job that is not an error job has a base from two to sixteen.
  a_err_class: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && !job.err) |-> (job.radix >= RADIX_MIN && job.radix <= RADIX_MAX))
    else $error("valid job with bad base");

endmodule

[rtl/u2a_back.sv]
module u2a_back import u2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last,
  output logic               out_error
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   value_r;
  logic [RADIX_W-1:0]  base_r;
  logic [DATA_W-1:0]   recip_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [DIGIT_W-1:0]  stk_r [DATA_W];

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;
  logic                out_err_r;

  logic                out_free;
  logic                take_job, push, pop;
  logic [DATA_W-1:0]   q_est, q_fix;
  logic [DATA_W+RADIX_W-1:0] qb;
  logic [DATA_W-1:0]   r_est, r_fix, base_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign job_ready = (state_r == ST_IDLE) && out_free;
  assign take_job  = job_valid && job_ready;
  assign push      = (state_r == ST_FIX);
  assign pop       = (state_r == ST_EMIT) && out_free;

  // Quotient correction: the estimate is at most one short.
  always_comb begin
    base_ext = {{(DATA_W - RADIX_W){1'b0}}, base_r};
    q_est    = prod_r[2*DATA_W-1:DATA_W];
    qb       = q_est * base_r;
    r_est    = value_r - qb[DATA_W-1:0];
    if (r_est >= base_ext) begin
      q_fix = q_est + 1'b1;
      r_fix = r_est - base_ext;
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
  end

  // Sequencer: take a job, divide out digits, then pop them MSB first; an error job goes straight to the output.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (take_job) begin
          cnt_nxt = '0;
          if (job.err) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (q_fix == '0) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers of the divider.
  always_ff @(posedge clk) begin
    if (take_job) begin
      value_r <= job.value;
      base_r  <= job.radix;
      recip_r <= u2a_recip(job.radix);
    end else if (push) begin
      value_r <= q_fix;
    end
    if (state_r == ST_MUL) begin
      prod_r <= value_r * recip_r;
    end
  end

  // Digit stack as a shift line: push in at the bottom, pop from the bottom.
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= r_fix[DIGIT_W-1:0];
      for (int i = 1; i < DATA_W; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DATA_W - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (take_job && job.err) begin
      out_char_r <= CHAR_NONE;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (pop) begin
      out_char_r <= u2a_char(stk_r[0]);
      out_last_r <= (cnt_r == CNT_W'(1));
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_error      = out_err_r;

  // The corrected remainder is always a legal digit of the base.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |-> (r_fix < base_ext))
    else $error("remainder not below base");

  // The digit count stays within the stack depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DATA_W))
    else $error("digit count beyond stack depth");

  // Emitting always has at least one digit left.
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("emit with empty stack");

  // An error result is a lone NUL character that closes its conversion.
  a_err_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && out_char_r == CHAR_NONE))
    else $error("malformed error result");

endmodule

[rtl/unsigned_to_ascii_radix.sv]
// Converts an unsigned value to its digits in a base from 2 to 16, given as
// lower-case ASCII characters, most significant first, one output item per
// character, with last set on the final one. Zero gives a single '0'; a base
// of 0, 1 or above 16 gives one item with character 0, last and error set.
// A front queue of two entries takes and classifies input items; the back
// divider works one item at a time. Each digit takes a reciprocal multiply
// (state ST_MUL), then a one-step quotient correction (state ST_FIX); once
// all digits are found, each character is popped into the output register
// as the output accepts it. An error item goes straight to the output
// register.
module unsigned_to_ascii_radix import u2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PORT_W-1:0]  in_value,
  input  logic [RADIX_W-1:0] in_radix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last,
  output logic               out_error
);

  logic job_valid;
  logic job_ready;
  job_t job;

  u2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .in_radix  (in_radix),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  u2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_error      (out_error)
  );

endmodule
